FILE: design/lcs_pkg.sv
// Shared types, constants and helper functions of the RGB LED current scaler.
package lcs_pkg;

    // Lightbar geometry
    localparam int LED_COUNT   = 4;
    localparam int LED_IW      = 2;
    localparam int STORE_DEPTH = 3 * LED_COUNT;
    localparam int STORE_IW    = $clog2(STORE_DEPTH);

    // Init table
    localparam int INIT_LEN    = 14;
    localparam int INIT_IW     = $clog2(INIT_LEN);
    localparam int INIT_WRITES = 2 * INIT_LEN;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Driver register map
    localparam logic [7:0] BANK_EVEN    = 8'h15;
    localparam logic [7:0] BANK_ODD     = 8'h18;
    localparam logic [7:0] MODE_REG     = 8'h01;
    localparam logic [7:0] MODE_ACTIVE  = 8'h20;
    localparam logic [7:0] MODE_STANDBY = 8'h00;

    // Reset values
    localparam logic [7:0] RED_LIMIT_RST   = 8'd92;
    localparam logic [7:0] GREEN_LIMIT_RST = 8'd56;
    localparam logic [7:0] BLUE_LIMIT_RST  = 8'd103;
    localparam logic [7:0] LEVEL_RST       = 8'd255;

    localparam logic [7:0] INIT_ADDR [INIT_LEN] = '{
        8'h04, 8'h05, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13,
        8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a
    };
    localparam logic [7:0] INIT_DATA [INIT_LEN] = '{
        8'h00, 8'h3f, 8'h01, 8'h3f, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        ACT_SET_COLOR  = 3'd0,
        ACT_SET_BRIGHT = 3'd1,
        ACT_INIT       = 3'd2,
        ACT_WAKE       = 3'd3,
        ACT_SLEEP      = 3'd4,
        ACT_RAW        = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        CFG_RED   = 2'd0,
        CFG_GREEN = 2'd1,
        CFG_BLUE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        JOB_COLOR,
        JOB_BRIGHT,
        JOB_INIT,
        JOB_WAKE,
        JOB_SLEEP,
        JOB_RAW
    } t_job_kind;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL1,
        SEQ_MUL2,
        SEQ_EMIT,
        SEQ_FIXED
    } t_seq_state;

    typedef struct packed {
        t_job_kind         kind;
        logic              all_leds;
        logic [LED_IW-1:0] led;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        level;
        logic              ctrl;
        logic [7:0]        reg_req;
        logic [7:0]        value;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] data;
    } t_cfg_wr;

    // Exact x / 255 for any x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // Colour channel order on the bus: blue, red, green
    function automatic logic [1:0] chan_offset(input logic [1:0] ch);
        logic [1:0] o;
        unique case (ch)
            2'd0:    o = 2'd2;
            2'd1:    o = 2'd0;
            default: o = 2'd1;
        endcase
        return o;
    endfunction

endpackage

FILE: design/lcs_cmd_if.sv
// Command channel: one lightbar command per word.
interface lcs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic       ctrl;
    logic [7:0] reg_req;
    logic [7:0] value;

    modport source (
        output valid, action, led, red, green, blue, level, ctrl, reg_req, value,
        input  ready
    );
    modport sink (
        input  valid, action, led, red, green, blue, level, ctrl, reg_req, value,
        output ready
    );
endinterface

FILE: design/lcs_wr_if.sv
// Driver write channel: one register write per word.
interface lcs_wr_if;
    logic       valid;
    logic       ready;
    logic       controller;
    logic [7:0] reg_addr;
    logic [7:0] reg_value;
    logic       last;

    modport source (
        output valid, controller, reg_addr, reg_value, last,
        input  ready
    );
    modport sink (
        input  valid, controller, reg_addr, reg_value, last,
        output ready
    );
endinterface

FILE: design/lcs_front.sv
// Command decoder: classifies each command word into a job for the queue.
module lcs_front
    import lcs_pkg::*;
(
    lcs_cmd_if.sink   i_cmd,
    input  t_q_stat   i_q_stat,
    output logic      o_push,
    output t_job      o_job
);

    logic known;

    always_comb begin
        known        = 1'b1;
        o_job.kind   = JOB_RAW;
        unique case (t_action'(i_cmd.action))
            ACT_SET_COLOR:  o_job.kind = JOB_COLOR;
            ACT_SET_BRIGHT: o_job.kind = JOB_BRIGHT;
            ACT_INIT:       o_job.kind = JOB_INIT;
            ACT_WAKE:       o_job.kind = JOB_WAKE;
            ACT_SLEEP:      o_job.kind = JOB_SLEEP;
            ACT_RAW:        o_job.kind = JOB_RAW;
            default:        known      = 1'b0;    // drop unused codes
        endcase
        o_job.all_leds = (i_cmd.led >= 8'(LED_COUNT));
        o_job.led      = i_cmd.led[LED_IW-1:0];
        o_job.red      = i_cmd.red;
        o_job.green    = i_cmd.green;
        o_job.blue     = i_cmd.blue;
        o_job.level    = i_cmd.level;
        o_job.ctrl     = i_cmd.ctrl;
        o_job.reg_req  = i_cmd.reg_req;
        o_job.value    = i_cmd.value;
    end

    assign i_cmd.ready = !i_q_stat.full;
    assign o_push      = i_cmd.valid && !i_q_stat.full && known;

endmodule

FILE: design/lcs_queue.sv
// Short job queue between the decoder and the write sequencer.
module lcs_queue
    import lcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count,  n_count;
    logic                do_push, do_pop;

    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: design/lcs_back.sv
// Write sequencer: colour store, current scaling and the driver write register.
module lcs_back
    import lcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  t_job    i_job,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    lcs_wr_if.source o_wr
);

    t_seq_state          r_state, n_state;
    t_job                r_job,   n_job;
    logic [LED_IW-1:0]   r_led,   n_led;
    logic [LED_IW-1:0]   r_end,   n_end;
    logic [1:0]          r_ch,    n_ch;
    logic [INIT_IW:0]    r_idx,   n_idx;
    logic [7:0]          r_level, n_level;
    logic [15:0]         r_p1,    n_p1;
    logic [15:0]         r_p2,    n_p2;

    logic [7:0]          r_red_limit, r_green_limit, r_blue_limit;
    logic [7:0]          r_store [STORE_DEPTH];

    logic                r_out_valid, n_out_valid;
    logic                r_out_ctrl,  n_out_ctrl;
    logic [7:0]          r_out_addr,  n_out_addr;
    logic [7:0]          r_out_data,  n_out_data;
    logic                r_out_last,  n_out_last;

    logic                can_load;
    logic                store_fill;
    logic                store_clear;
    logic [STORE_IW-1:0] rd_idx;
    logic [7:0]          limit;
    logic [7:0]          bank;
    logic                led_done;

    assign can_load = !r_out_valid || o_wr.ready;
    assign rd_idx   = STORE_IW'({r_led, 1'b0}) + STORE_IW'(r_led)
                    + STORE_IW'(chan_offset(r_ch));
    assign bank     = r_led[0] ? BANK_ODD : BANK_EVEN;
    assign led_done = (r_ch == 2'd2);

    always_comb begin
        unique case (r_ch)
            2'd0:    limit = r_blue_limit;
            2'd1:    limit = r_red_limit;
            default: limit = r_green_limit;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_led       = r_led;
        n_end       = r_end;
        n_ch        = r_ch;
        n_idx       = r_idx;
        n_level     = r_level;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_out_valid = r_out_valid && !o_wr.ready;
        n_out_ctrl  = r_out_ctrl;
        n_out_addr  = r_out_addr;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        store_fill  = 1'b0;
        store_clear = 1'b0;

        unique case (r_state)
            SEQ_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_ch  = 2'd0;
                    n_idx = '0;
                    unique case (i_job.kind)
                        JOB_COLOR: begin
                            store_fill = 1'b1;
                            n_led      = i_job.all_leds ? '0 : i_job.led;
                            n_end      = i_job.all_leds ? LED_IW'(LED_COUNT - 1) : i_job.led;
                            n_state    = SEQ_MUL1;
                        end
                        JOB_BRIGHT: begin
                            n_level = i_job.level;
                            n_led   = '0;
                            n_end   = LED_IW'(LED_COUNT - 1);
                            n_state = SEQ_MUL1;
                        end
                        JOB_INIT: begin
                            store_clear = 1'b1;
                            n_state     = SEQ_FIXED;
                        end
                        default: n_state = SEQ_FIXED;
                    endcase
                end
            end
            SEQ_MUL1: begin
                n_p1    = r_store[rd_idx] * r_level;
                n_state = SEQ_MUL2;
            end
            SEQ_MUL2: begin
                n_p2    = div255(r_p1) * limit;
                n_state = SEQ_EMIT;
            end
            SEQ_EMIT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_ctrl  = r_led[1];
                    n_out_addr  = bank + 8'(r_ch);
                    n_out_data  = div255(r_p2);
                    n_out_last  = led_done && (r_led == r_end);
                    // advance channel, then LED
                    if (!led_done) begin
                        n_ch    = r_ch + 1'b1;
                        n_state = SEQ_MUL1;
                    end else if (r_led == r_end) begin
                        n_state = SEQ_IDLE;
                    end else begin
                        n_ch    = 2'd0;
                        n_led   = r_led + 1'b1;
                        n_state = SEQ_MUL1;
                    end
                end
            end
            SEQ_FIXED: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_ctrl  = r_idx[0];
                    n_out_addr  = MODE_REG;
                    n_out_data  = MODE_STANDBY;
                    n_out_last  = (r_idx == (INIT_IW + 1)'(1));
                    priority case (r_job.kind)
                        JOB_INIT: begin
                            n_out_addr = INIT_ADDR[r_idx[INIT_IW:1]];
                            n_out_data = INIT_DATA[r_idx[INIT_IW:1]];
                            n_out_last = (r_idx == (INIT_IW + 1)'(INIT_WRITES - 1));
                        end
                        JOB_WAKE: begin
                            n_out_data = MODE_ACTIVE;
                        end
                        JOB_RAW: begin
                            n_out_ctrl = r_job.ctrl;
                            n_out_addr = r_job.reg_req;
                            n_out_data = r_job.value;
                            n_out_last = 1'b1;
                        end
                        default: ;
                    endcase
                    n_idx   = r_idx + 1'b1;
                    n_state = n_out_last ? SEQ_IDLE : SEQ_FIXED;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_out_valid <= 1'b0;
            r_level     <= LEVEL_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_level     <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_led      <= n_led;
        r_end      <= n_end;
        r_ch       <= n_ch;
        r_idx      <= n_idx;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_out_ctrl <= n_out_ctrl;
        r_out_addr <= n_out_addr;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // Current limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_limit   <= RED_LIMIT_RST;
            r_green_limit <= GREEN_LIMIT_RST;
            r_blue_limit  <= BLUE_LIMIT_RST;
        end else if (i_cfg.we) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                CFG_RED:   r_red_limit   <= i_cfg.data;
                CFG_GREEN: r_green_limit <= i_cfg.data;
                CFG_BLUE:  r_blue_limit  <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // Colour store: red, green, blue per LED
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || store_clear) begin
            for (int e = 0; e < STORE_DEPTH; e++) begin
                r_store[e] <= '0;
            end
        end else if (store_fill) begin
            for (int l = 0; l < LED_COUNT; l++) begin
                if (i_job.all_leds || (i_job.led == LED_IW'(l))) begin
                    r_store[3 * l]     <= i_job.red;
                    r_store[3 * l + 1] <= i_job.green;
                    r_store[3 * l + 2] <= i_job.blue;
                end
            end
        end
    end

    assign o_wr.valid      = r_out_valid;
    assign o_wr.controller = r_out_ctrl;
    assign o_wr.reg_addr   = r_out_addr;
    assign o_wr.reg_value  = r_out_data;
    assign o_wr.last       = r_out_last;

endmodule

FILE: design/rgb_led_current_scaler.sv
// Top level of the RGB LED current scaler: decoder, job queue and write sequencer.
// Path: a command word is registered in the queue, then taken by the sequencer; fixed
//   writes (init, wake, standby, raw) go to the write register from its fixed state, and
//   scaled colour writes pass first through its two multiply stages and its emit state.
// Throughput: fixed writes go out one per cycle while the driver holds ready high.
// Reset: synchronous, active low; clears the colour store and the queue, sets the
//   brightness to 255 and the red, green and blue limits to 92, 56 and 103.
module rgb_led_current_scaler
    import lcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    lcs_cmd_if.sink    i_cmd,
    lcs_wr_if.source   o_wr
);

    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_cfg_wr cfg;

    // Bundle the limit write port for the sequencer
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Decode each command word; unused codes are taken and dropped
    lcs_front u_front (
        .i_cmd    (i_cmd),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (front_job)
    );

    // Hold decoded jobs so the decoder keeps taking words while writes drain
    lcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // Run one job at a time and drive the registered write word
    lcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_wr     (o_wr)
    );

endmodule
